// ===== hdl/hash_frequency_counter_top_assert.svh =====
// ----------------------------------------------------------------------------
// hash frequency counter assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef HASH_FREQUENCY_COUNTER_TOP_ASSERT_SVH
`define HASH_FREQUENCY_COUNTER_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define HFC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define HFC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/hfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hfc_pkg
// shared types and constants of the hash frequency counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hfc_pkg;

	localparam int unsigned ACT_W      = 2;
	localparam int unsigned KEY_W      = 31;
	localparam int unsigned RES_CNT_W  = 16;
	localparam int unsigned WIDE_CNT_W = 32;
	localparam int unsigned HASH_MULT  = 17;
	localparam int unsigned PROBE_STEP = 23;

	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [RES_CNT_W-1:0]  res_count_t;
	typedef logic [WIDE_CNT_W-1:0] wide_count_t;

	typedef enum logic [ACT_W-1:0] {
		ACT_CLEAR  = 2'd0,
		ACT_INSERT = 2'd1,
		ACT_QUERY  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_PROBE,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic clear;
		logic update;
	} best_ctl_t;

endpackage

// ===== hdl/hfc_if.sv =====
// ----------------------------------------------------------------------------
// hfc channel interfaces
// command channel and result channel, valid/ready handshake
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface hfc_cmd_if;
	logic                           valid;
	logic                           ready;
	logic [hfc_pkg::ACT_W-1:0]      action;
	hfc_pkg::key_t                  key_in;

	modport source (output valid, output action, output key_in, input ready);
	modport sink (input valid, input action, input key_in, output ready);
endinterface

interface hfc_res_if;
	logic                  valid;
	logic                  ready;
	hfc_pkg::key_t         result_key;
	hfc_pkg::res_count_t   result_count;
	logic                  found;
	logic                  table_full;

	modport source (output valid, output result_key, output result_count, output found,
		output table_full, input ready);
	modport sink (input valid, input result_key, input result_count, input found,
		input table_full, output ready);
endinterface

// ===== hdl/hfc_best.sv =====
// ----------------------------------------------------------------------------
// hfc_best
// most frequent entry tracker: highest count, lowest slot on a tie
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hfc_best #(
	parameter int unsigned SLOT_W     = 10,
	parameter int unsigned COUNT_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  hfc_pkg::best_ctl_t    ctl,
	input  logic [SLOT_W-1:0]     slot,
	input  logic [COUNT_BITS-1:0] count,
	input  hfc_pkg::key_t         key,
	output logic [COUNT_BITS-1:0] best_count,
	output hfc_pkg::key_t         best_key
);

	logic [SLOT_W-1:0]     best_slot_q;
	logic [COUNT_BITS-1:0] best_count_q;
	hfc_pkg::key_t         best_key_q;
	logic                  wins;

	assign wins = (count > best_count_q) || ((count == best_count_q) && (slot < best_slot_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_slot_q  <= '0;
			best_count_q <= '0;
			best_key_q   <= '0;
		end else if (ctl.clear) begin
			best_slot_q  <= '0;
			best_count_q <= '0;
			best_key_q   <= '0;
		end else if (ctl.update && wins) begin
			best_slot_q  <= slot;
			best_count_q <= count;
			best_key_q   <= key;
		end
	end

	assign best_count = best_count_q;
	assign best_key   = best_key_q;

endmodule

// ===== hdl/hash_frequency_counter_top.sv =====
// ----------------------------------------------------------------------------
// hash_frequency_counter_top: open addressing hash table of key counts
// insert walks the probe chain, one probe per cycle through the single table memory;
// query and unused codes go straight to the result, clear after a sweep of every slot
// reset starts a clearing pass over all 2^TABLE_BITS slots with the command side stalled
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hash_frequency_counter_top #(
	parameter int unsigned TABLE_BITS = 10,  // table holds 2^TABLE_BITS slots, 4 to 16
	parameter int unsigned COUNT_BITS = 16   // stored count width, 4 to 32
) (
	input logic        clk,
	input logic        arst_n,
	hfc_cmd_if.sink    cmd,
	hfc_res_if.source  res
);

	localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;
	localparam int unsigned WORD_W     = 1 + hfc_pkg::KEY_W + COUNT_BITS;
	localparam int unsigned HASH_W     = TABLE_BITS + 5;
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [TABLE_BITS-1:0] STEP      = TABLE_BITS'(hfc_pkg::PROBE_STEP);

	// one table word: {used, key, count}
	logic [WORD_W-1:0]     table_mem [TABLE_SIZE];
	logic [WORD_W-1:0]     rd_word_q;
	logic                  mem_we;
	logic [TABLE_BITS-1:0] mem_waddr;
	logic [TABLE_BITS-1:0] mem_raddr;
	logic [WORD_W-1:0]     mem_wdata;

	hfc_pkg::state_t       state_q;
	hfc_pkg::state_t       state_d;
	logic [TABLE_BITS-1:0] sweep_q;
	logic [TABLE_BITS-1:0] probe_q;
	logic [TABLE_BITS-1:0] slot_q;
	hfc_pkg::key_t         key_q;

	// result waiting for the output register
	hfc_pkg::key_t         res_key_q;
	hfc_pkg::res_count_t   res_count_q;
	logic                  res_found_q;
	logic                  res_full_q;

	// output register
	logic                  out_valid_q;
	hfc_pkg::key_t         out_key_q;
	hfc_pkg::res_count_t   out_count_q;
	logic                  out_found_q;
	logic                  out_full_q;

	logic                  cmd_ready;
	logic                  cmd_acc;
	logic                  out_free;
	logic                  sweep_last;
	logic                  probe_last;
	logic [HASH_W-1:0]     hash_full;
	logic [TABLE_BITS-1:0] hash;

	logic                  rd_used;
	hfc_pkg::key_t         rd_key;
	logic [COUNT_BITS-1:0] rd_count;
	logic                  probe_hit;
	logic [COUNT_BITS-1:0] new_count;

	hfc_pkg::best_ctl_t    best_ctl;
	logic [COUNT_BITS-1:0] best_count;
	hfc_pkg::key_t         best_key;

	// table memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
		rd_word_q <= table_mem[mem_raddr];
	end

	assign rd_used  = rd_word_q[WORD_W-1];
	assign rd_key   = rd_word_q[WORD_W-2 -: hfc_pkg::KEY_W];
	assign rd_count = rd_word_q[COUNT_BITS-1:0];

	// key*17 mod table size keeps only the low index bits
	assign hash_full = HASH_W'(cmd.key_in[TABLE_BITS-1:0]) * HASH_W'(hfc_pkg::HASH_MULT);
	assign hash      = hash_full[TABLE_BITS-1:0];

	// a free slot or the same key ends the probe sequence
	assign probe_hit  = !rd_used || (rd_key == key_q);
	assign probe_last = &probe_q;
	assign sweep_last = &sweep_q;

	// saturating increment, a fresh slot starts at one
	always_comb begin
		if (!rd_used) begin
			new_count = COUNT_BITS'(1);
		end else if (rd_count == COUNT_MAX) begin
			new_count = rd_count;
		end else begin
			new_count = rd_count + COUNT_BITS'(1);
		end
	end

	assign cmd_acc  = cmd.valid && cmd_ready;
	assign out_free = !out_valid_q || res.ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			hfc_pkg::ST_INIT: begin
				if (sweep_last) state_d = hfc_pkg::ST_IDLE;
			end
			hfc_pkg::ST_IDLE: begin
				if (cmd.valid) begin
					unique case (hfc_pkg::action_t'(cmd.action))
						hfc_pkg::ACT_CLEAR:  state_d = hfc_pkg::ST_CLEAR;
						hfc_pkg::ACT_INSERT: state_d = hfc_pkg::ST_PROBE;
						default:             state_d = hfc_pkg::ST_EMIT;
					endcase
				end
			end
			hfc_pkg::ST_CLEAR: begin
				if (sweep_last) state_d = hfc_pkg::ST_EMIT;
			end
			hfc_pkg::ST_PROBE: begin
				if (probe_hit || probe_last) state_d = hfc_pkg::ST_EMIT;
			end
			hfc_pkg::ST_EMIT: begin
				if (out_free) state_d = hfc_pkg::ST_IDLE;
			end
			default: state_d = hfc_pkg::ST_INIT;
		endcase
	end

	// memory and tracker controls
	always_comb begin
		cmd_ready       = 1'b0;
		mem_we          = 1'b0;
		mem_waddr       = sweep_q;
		mem_wdata       = '0;
		mem_raddr       = slot_q;
		best_ctl.clear  = 1'b0;
		best_ctl.update = 1'b0;
		unique case (state_q)
			hfc_pkg::ST_INIT, hfc_pkg::ST_CLEAR: begin
				// clearing pass writes empty words, one slot per cycle
				mem_we = 1'b1;
			end
			hfc_pkg::ST_IDLE: begin
				cmd_ready      = 1'b1;
				mem_raddr      = hash;
				best_ctl.clear = cmd.valid
					&& (hfc_pkg::action_t'(cmd.action) == hfc_pkg::ACT_CLEAR);
			end
			hfc_pkg::ST_PROBE: begin
				// read ahead at the next probe slot while this one is checked
				mem_raddr       = slot_q + STEP;
				mem_we          = probe_hit;
				mem_waddr       = slot_q;
				mem_wdata       = {1'b1, key_q, new_count};
				best_ctl.update = probe_hit;
			end
			default: begin
			end
		endcase
	end

	assign cmd.ready = cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hfc_pkg::ST_INIT;
			sweep_q <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == hfc_pkg::ST_INIT) || (state_q == hfc_pkg::ST_CLEAR)) begin
				sweep_q <= sweep_q + TABLE_BITS'(1);
			end
		end
	end

	// probe address, probe count and the pending result
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			slot_q      <= hash;
			probe_q     <= '0;
			key_q       <= cmd.key_in;
			res_key_q   <= '0;
			res_count_q <= '0;
			res_found_q <= 1'b0;
			res_full_q  <= 1'b0;
			if ((hfc_pkg::action_t'(cmd.action) == hfc_pkg::ACT_QUERY)
				&& (best_count != '0)) begin
				res_key_q   <= best_key;
				res_count_q <= hfc_pkg::res_count_t'(hfc_pkg::wide_count_t'(best_count));
				res_found_q <= 1'b1;
			end
		end else if (state_q == hfc_pkg::ST_PROBE) begin
			slot_q  <= slot_q + STEP;
			probe_q <= probe_q + TABLE_BITS'(1);
			if (probe_hit) begin
				res_key_q   <= key_q;
				res_count_q <= hfc_pkg::res_count_t'(hfc_pkg::wide_count_t'(new_count));
				res_found_q <= 1'b1;
			end else if (probe_last) begin
				// every slot taken by other keys: drop the key
				res_key_q   <= key_q;
				res_count_q <= '0;
				res_full_q  <= 1'b1;
			end
		end
	end

	// output register frees the core while a result waits downstream
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == hfc_pkg::ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == hfc_pkg::ST_EMIT) && out_free) begin
			out_key_q   <= res_key_q;
			out_count_q <= res_count_q;
			out_found_q <= res_found_q;
			out_full_q  <= res_full_q;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.result_key   = out_key_q;
	assign res.result_count = out_count_q;
	assign res.found        = out_found_q;
	assign res.table_full   = out_full_q;

	// most frequent entry, offered every successful insert and taken when it wins
	hfc_best #(
		.SLOT_W     (TABLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_best (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (best_ctl),
		.slot       (slot_q),
		.count      (new_count),
		.key        (key_q),
		.best_count (best_count),
		.best_key   (best_key)
	);

endmodule

// ===== hdl/hfc_checker.sv =====
// ----------------------------------------------------------------------------
// hfc_checker
// port level checks on the result channel of the hash frequency counter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "hash_frequency_counter_top_assert.svh"

module hfc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                res_valid,
	input logic                res_ready,
	input hfc_pkg::key_t       result_key,
	input hfc_pkg::res_count_t result_count,
	input logic                found,
	input logic                table_full
);

	// a stalled item stays offered
	`HFC_ASSERT_NEXT(a_res_hold, clk, arst_n, res_valid && !res_ready, res_valid, "result dropped while stalled")

	// a dropped key is never also reported as counted
	`HFC_ASSERT_SAME(a_flags_excl, clk, arst_n, res_valid, !(found && table_full), "found and table_full both set")

	// no valid key means no count
	`HFC_ASSERT_SAME(a_miss_count, clk, arst_n, res_valid && !found, result_count == '0, "count without a found key")

	// clear, empty query and unused codes give an all-zero item
	`HFC_ASSERT_SAME(a_zero_key, clk, arst_n, res_valid && !found && !table_full, result_key == '0, "key set on an empty item")

endmodule

bind hash_frequency_counter_top hfc_checker u_hfc_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (res.valid),
	.res_ready    (res.ready),
	.result_key   (res.result_key),
	.result_count (res.result_count),
	.found        (res.found),
	.table_full   (res.table_full)
);

// ===== dv/tb_hash_frequency_counter_top.sv =====
// ----------------------------------------------------------------------------
// tb_hash_frequency_counter_top
// clear, insert, query and unused-code items against a software count table
// directed corner cases, random mixes under idle and stall patterns, full table
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_hash_frequency_counter_top;

	import hfc_pkg::*;

	localparam int unsigned TABLE_BITS = 10;
	localparam int unsigned COUNT_BITS = 16;
	localparam int unsigned TABLE_SIZE = 1 << TABLE_BITS;
	localparam longint unsigned COUNT_MAX = (64'd1 << COUNT_BITS) - 1;
	localparam int unsigned CLK_PERIOD = 10;
	localparam int unsigned POOL_SIZE = 32;
	localparam longint unsigned LIMIT_NS = 64'd50_000_000;

	// code three has no enum member in the package; the block must ignore it
	localparam logic [ACT_W-1:0] ACT_RESERVED = 2'd3;

	typedef longint unsigned u64_t;

	// one result item as seen on the result channel
	typedef struct packed {
		key_t       key;
		res_count_t cnt;
		logic       found;
		logic       tbl_full;
	} tally_t;

	// ------------------------------------------------------------------------
	// software copy of the count table plus the queue of results still owed
	// ------------------------------------------------------------------------
	class key_tally_sb;
		key_t        slot_key   [TABLE_SIZE];
		bit          slot_used  [TABLE_SIZE];
		int unsigned slot_count [TABLE_SIZE];
		int unsigned best_slot;
		int unsigned best_count;
		key_t        best_key;
		tally_t      pending_tallies[$];
		int unsigned mismatches;

		function new();
			mismatches = 0;
			wipe();
		endfunction

		function void wipe();
			foreach (slot_used[i]) begin
				slot_used[i]  = 1'b0;
				slot_count[i] = 0;
				slot_key[i]   = '0;
			end
			best_slot  = 0;
			best_count = 0;
			best_key   = '0;
		endfunction

		// work out the result of an accepted command and queue it
		function void note_command(logic [ACT_W-1:0] act, key_t key);
			tally_t      want;
			int unsigned h;
			int unsigned probes;
			bit          hit;
			want = '{key: '0, cnt: '0, found: 1'b0, tbl_full: 1'b0};
			case (act)
				ACT_CLEAR: begin
					wipe();
				end
				ACT_QUERY: begin
					if (best_count != 0)
						want = '{key: best_key, cnt: res_count_t'(best_count),
							found: 1'b1, tbl_full: 1'b0};
				end
				ACT_INSERT: begin
					h      = int'((u64_t'(key) * HASH_MULT) % TABLE_SIZE);
					probes = 0;
					hit    = 1'b0;
					// walk the probe chain until the key or a free slot turns up
					while (!hit && probes < TABLE_SIZE) begin
						if (!slot_used[h] || slot_key[h] == key)
							hit = 1'b1;
						else begin
							h = (h + PROBE_STEP) % TABLE_SIZE;
							probes++;
						end
					end
					if (!hit) begin
						want = '{key: key, cnt: '0, found: 1'b0, tbl_full: 1'b1};
					end else begin
						if (!slot_used[h]) begin
							slot_used[h]  = 1'b1;
							slot_key[h]   = key;
							slot_count[h] = 0;
						end
						if (slot_count[h] < COUNT_MAX)
							slot_count[h]++;
						if (slot_count[h] > best_count ||
							(slot_count[h] == best_count && h < best_slot)) begin
							best_count = slot_count[h];
							best_slot  = h;
							best_key   = key;
						end
						want = '{key: key, cnt: res_count_t'(slot_count[h]),
							found: 1'b1, tbl_full: 1'b0};
					end
				end
				default: begin
				end
			endcase
			pending_tallies.push_back(want);
		endfunction

		// compare one accepted result with the oldest owed one
		function void check_result(key_t key, res_count_t cnt, logic found, logic tbl_full);
			tally_t want;
			if (pending_tallies.size() == 0) begin
				$display("%0t: unexpected result, key %0d count %0d found %0b full %0b",
					$time, key, cnt, found, tbl_full);
				mismatches++;
				return;
			end
			want = pending_tallies.pop_front();
			if (key !== want.key) begin
				$display("%0t: result_key expected %0d, actual %0d", $time, want.key, key);
				mismatches++;
			end
			if (cnt !== want.cnt) begin
				$display("%0t: result_count expected %0d, actual %0d", $time, want.cnt, cnt);
				mismatches++;
			end
			if (found !== want.found) begin
				$display("%0t: found expected %0b, actual %0b", $time, want.found, found);
				mismatches++;
			end
			if (tbl_full !== want.tbl_full) begin
				$display("%0t: table_full expected %0b, actual %0b", $time, want.tbl_full,
					tbl_full);
				mismatches++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset, channels and the block
	// ------------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n;

	always #(CLK_PERIOD / 2) clk = ~clk;

	hfc_cmd_if cmd_ch ();
	hfc_res_if res_ch ();

	hash_frequency_counter_top #(
		.TABLE_BITS (TABLE_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.res    (res_ch)
	);

	key_tally_sb sb = new();

	// idle and stall odds in percent, changed per phase by the stimulus
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	// a nonzero value asks the receiver for a long hold-off, counted down in hold_left
	int unsigned hold_req = 0;
	int unsigned hold_left = 0;

	key_t fill_keys [TABLE_SIZE];

	// ------------------------------------------------------------------------
	// receiver: checks each accepted result, then picks the next ready level
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else begin
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.result_key, res_ch.result_count, res_ch.found,
					res_ch.table_full);
			// a pending hold-off request takes over from the random stall
			if (hold_req != 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left != 0) begin
				hold_left--;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
			end
		end
	end

	// ------------------------------------------------------------------------
	// sender: one command item, with random idle cycles ahead of it
	// ------------------------------------------------------------------------
	task automatic send_item(logic [ACT_W-1:0] act, key_t key);
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid  <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.key_in <= key;
		@(posedge clk);
		// ready is sampled before this edge's updates, so this is the handshake
		while (!cmd_ch.ready)
			@(posedge clk);
		sb.note_command(act, key);
	endtask

	// random mix: mostly inserts from a small key pool so counts grow and
	// probe chains get long, plus stray keys, queries, clears and code three
	task automatic random_phase(int unsigned n_items, int unsigned idle_pct,
		int unsigned stall_pct, bit with_hold);
		key_t        key_pool [POOL_SIZE];
		int unsigned pick;
		int unsigned n;
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		// half the pool shares a few home slots, forcing collisions
		foreach (key_pool[i]) begin
			key_pool[i] = key_t'($urandom());
			if (i % 2 == 0)
				key_pool[i][TABLE_BITS-1:0] = TABLE_BITS'($urandom_range(0, 2));
		end
		for (n = 0; n < n_items; n++) begin
			// long receiver hold-off while the sender keeps offering items
			if (with_hold && n == 60)
				hold_req = 400;
			pick = $urandom_range(0, 99);
			if (pick < 1)
				send_item(ACT_CLEAR, key_t'($urandom()));
			else if (pick < 3)
				send_item(ACT_RESERVED, key_t'($urandom()));
			else if (pick < 15)
				send_item(ACT_QUERY, key_t'($urandom()));
			else if (pick < 25)
				send_item(ACT_INSERT, key_t'($urandom()));
			else
				send_item(ACT_INSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
		end
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		cmd_ch.valid  <= 1'b0;
		cmd_ch.action <= ACT_CLEAR;
		cmd_ch.key_in <= '0;
		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: the clearing pass after reset just shows up as a stalled input
		send_item(ACT_QUERY, 31'h7FFF_FFFF);        // empty table
		send_item(ACT_INSERT, 31'h0000_0000);
		send_item(ACT_INSERT, 31'h7FFF_FFFF);
		send_item(ACT_INSERT, 31'h7FFF_FFFF);       // second hit on same key
		send_item(ACT_QUERY, 31'h0000_0000);
		send_item(ACT_RESERVED, 31'h7FFF_FFFF);     // no state change
		send_item(ACT_INSERT, 31'd1024);            // same home slot as key 0
		send_item(ACT_INSERT, 31'd2048);            // two probes deep
		send_item(ACT_INSERT, 31'd1024);            // tie on count, lower slot wins
		send_item(ACT_QUERY, 31'h0000_0000);
		send_item(ACT_INSERT, 31'h2AAA_AAAA);
		send_item(ACT_INSERT, 31'h5555_5555);
		send_item(ACT_CLEAR, 31'h0000_0000);
		send_item(ACT_QUERY, 31'h0000_0000);        // empty again after clear
		send_item(ACT_INSERT, 31'd60);              // home slot near the top
		send_item(ACT_INSERT, 31'd1);               // equal count, lower slot
		send_item(ACT_QUERY, 31'h0000_0000);
		send_item(ACT_INSERT, 31'd60);
		send_item(ACT_QUERY, 31'h0000_0000);
		send_item(ACT_RESERVED, 31'h0000_0000);
		send_item(ACT_CLEAR, 31'h7FFF_FFFF);        // key ignored on clear
		send_item(ACT_QUERY, 31'h0000_0000);

		// random mixes over the four idle and stall patterns
		random_phase(240, 0, 0, 1'b1);
		random_phase(240, 52, 0, 1'b0);
		random_phase(240, 0, 52, 1'b0);
		random_phase(240, 34, 34, 1'b0);

		// fill every slot: distinct low bits give distinct home slots
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		send_item(ACT_CLEAR, '0);
		foreach (fill_keys[i]) begin
			fill_keys[i] = {21'($urandom()), TABLE_BITS'(i)};
			send_item(ACT_INSERT, fill_keys[i]);
			if (i == TABLE_SIZE / 2)
				send_item(ACT_QUERY, '0);
		end
		// new keys now walk the whole table and get dropped
		send_item(ACT_INSERT, fill_keys[5] ^ 31'h4000_0000);
		send_item(ACT_INSERT, {~fill_keys[TABLE_SIZE-1][30:TABLE_BITS], {TABLE_BITS{1'b1}}});
		send_item(ACT_INSERT, fill_keys[1000]);     // a stored key still counts
		send_item(ACT_QUERY, '0);
		send_item(ACT_RESERVED, '0);

		// drain: every command has a result, so a short tail is enough
		cmd_ch.valid <= 1'b0;
		while (sb.pending_tallies.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// watchdog for a hung handshake
	initial begin
		#(LIMIT_NS);
		$display("Mismatches found");
		$finish;
	end

endmodule

// ===== hash_frequency_counter_top.f =====
+incdir+hdl
hdl/hfc_pkg.sv
hdl/hfc_if.sv
hdl/hfc_best.sv
hdl/hash_frequency_counter_top.sv
hdl/hfc_checker.sv
dv/tb_hash_frequency_counter_top.sv
